/* rtl/cep_pkg.sv */
// ----------------------------------------------------------------------------
// cep_pkg
// Shared types and constants for the convex ear polygon triangulator.
// ----------------------------------------------------------------------------
package cep_pkg;

  localparam int COORD_W   = 16;
  localparam int CORNER_W  = 5;
  localparam int MIN_VERTS = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cep_vertex_t;

  typedef struct packed {
    cep_vertex_t a;
    cep_vertex_t b;
    cep_vertex_t c;
  } cep_tri_t;

endpackage

/* rtl/cep_ram.sv */
// ----------------------------------------------------------------------------
// cep_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cep_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cep_cross.sv */
// ----------------------------------------------------------------------------
// cep_cross
// Two-stage cross product pipeline: differences, then products.
// Convex when (c - b) x (a - b) > 0.
// ----------------------------------------------------------------------------
module cep_cross
  import cep_pkg::*;
(
  input  logic     clk,
  input  cep_tri_t tri_i,
  output logic     convex_o
);

  localparam int DW = COORD_W + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dx1_r, dy1_r, dx2_r, dy2_r;
  logic signed [PW-1:0] p1_r, p2_r;

  always_ff @(posedge clk) begin
    dx1_r <= DW'(tri_i.c.x) - DW'(tri_i.b.x);
    dy1_r <= DW'(tri_i.c.y) - DW'(tri_i.b.y);
    dx2_r <= DW'(tri_i.a.x) - DW'(tri_i.b.x);
    dy2_r <= DW'(tri_i.a.y) - DW'(tri_i.b.y);
    p1_r  <= PW'(dx1_r) * PW'(dy2_r);
    p2_r  <= PW'(dy1_r) * PW'(dx2_r);
  end

  assign convex_o = (p1_r > p2_r);

endmodule

/* rtl/convex_ear_polygon_triangulator.sv */
// ----------------------------------------------------------------------------
// convex_ear_polygon_triangulator
// Loads a polygon one vertex per transfer, then clips convex ears and
// reports each triangle as the original indices of its three corners.
//
// Input channel: in_vertex_x/in_vertex_y with in_final_vertex on the last
// vertex. One vertex is taken per cycle while loading; in_ready is low from
// the final vertex until the last result of that polygon is in the output
// register.
// Output channel: one transfer per triangle; out_run_end marks the last one.
// Too few or too many vertices, or a ring with no convex vertex, gives one
// result with out_fault and out_run_end set and zero corners.
// The ring is a linked list in one-read-port RAMs. Each tested triple
// passes a next-pointer read, differences, products and a compare;
// each clipped ear first rereads the ring head.
// Reset clears the control state; the vertex RAMs need no clearing.
// A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module convex_ear_polygon_triangulator
  import cep_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  in_vertex_x,
  input  logic signed [COORD_W-1:0]  in_vertex_y,
  input  logic                       in_final_vertex,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CORNER_W-1:0]        out_corner_first,
  output logic [CORNER_W-1:0]        out_corner_middle,
  output logic [CORNER_W-1:0]        out_corner_third,
  output logic                       out_fault,
  output logic                       out_run_end
);

  localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int VW = 2 * COORD_W;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_RD3   = 4'd4;
  localparam logic [3:0] S_DIFF  = 4'd5;
  localparam logic [3:0] S_MULT  = 4'd6;
  localparam logic [3:0] S_TEST  = 4'd7;
  localparam logic [3:0] S_FINAL = 4'd8;
  localparam logic [3:0] S_FAULT = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, cn_r, cn_nxt;
  cep_tri_t      tri_r, tri_nxt;

  logic                out_valid_r;
  logic [CORNER_W-1:0] first_r, middle_r, third_r;
  logic                fault_r, end_r;

  logic                push;
  logic [CORNER_W-1:0] push_first, push_middle, push_third;
  logic                push_fault, push_end;
  logic                slot_free;

  logic          cw_en;
  logic [IW-1:0] cw_addr;
  cep_vertex_t   cw_data;
  logic          lw_en;
  logic [IW-1:0] lw_addr;
  logic [IW-1:0] lw_data;
  logic [IW-1:0] rd_addr;
  logic [VW-1:0] coord_rd_bits;
  cep_vertex_t   coord_rd;
  logic [IW-1:0] link_rd;
  logic          convex;

  logic          stored;
  logic [CW-1:0] new_cnt;

  cep_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES), .AW(IW)) u_coord_ram (
    .clk   (clk),
    .we    (cw_en),
    .waddr (cw_addr),
    .wdata (cw_data),
    .raddr (rd_addr),
    .rdata (coord_rd_bits)
  );

  assign coord_rd = cep_vertex_t'(coord_rd_bits);

  cep_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES), .AW(IW)) u_link_ram (
    .clk   (clk),
    .we    (lw_en),
    .waddr (lw_addr),
    .wdata (lw_data),
    .raddr (rd_addr),
    .rdata (link_rd)
  );

  cep_cross u_cross (
    .clk      (clk),
    .tri_i    (tri_r),
    .convex_o (convex)
  );

  assign in_ready  = (state_r == S_LOAD);
  assign slot_free = !out_valid_r || out_ready;
  assign stored    = (cnt_r < CW'(MAX_VERTICES));
  assign new_cnt   = cnt_r + CW'(stored);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    n_nxt       = n_r;
    i_nxt       = i_r;
    head_nxt    = head_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    cn_nxt      = cn_r;
    tri_nxt     = tri_r;
    push        = 1'b0;
    push_first  = '0;
    push_middle = '0;
    push_third  = '0;
    push_fault  = 1'b0;
    push_end    = 1'b0;
    cw_en       = 1'b0;
    cw_addr     = cnt_r[IW-1:0];
    cw_data     = '{x: in_vertex_x, y: in_vertex_y};
    lw_en       = 1'b0;
    lw_addr     = cnt_r[IW-1:0];
    lw_data     = in_final_vertex ? '0 : IW'(cnt_r + CW'(1));
    rd_addr     = head_r;

    case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cw_en = stored;
          lw_en = stored;
          if (in_final_vertex) begin
            if (ovf_r || !stored || (new_cnt < CW'(MIN_VERTS))) begin
              state_nxt = S_FAULT;
            end else if (new_cnt == CW'(MIN_VERTS)) begin
              head_nxt  = '0;
              a_nxt     = IW'(0);
              c_nxt     = IW'(1);
              cn_nxt    = IW'(2);
              state_nxt = S_FINAL;
            end else begin
              n_nxt     = new_cnt;
              head_nxt  = '0;
              state_nxt = S_RD0;
            end
          end else begin
            cnt_nxt = new_cnt;
            ovf_nxt = ovf_r | !stored;
          end
        end
      end
      S_RD0: begin
        rd_addr   = head_r;
        i_nxt     = '0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        a_nxt     = head_r;
        tri_nxt.a = coord_rd;
        b_nxt     = link_rd;
        rd_addr   = link_rd;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        tri_nxt.b = coord_rd;
        c_nxt     = link_rd;
        rd_addr   = link_rd;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        tri_nxt.c = coord_rd;
        cn_nxt    = link_rd;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        state_nxt = S_MULT;
      end
      S_MULT: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (convex) begin
          if (slot_free) begin
            push        = 1'b1;
            push_first  = CORNER_W'(a_r);
            push_middle = CORNER_W'(b_r);
            push_third  = CORNER_W'(c_r);
            lw_en       = 1'b1;
            lw_addr     = a_r;
            lw_data     = c_r;
            if (b_r == head_r) begin
              head_nxt = c_r;
            end
            n_nxt     = n_r - CW'(1);
            state_nxt = (n_r == CW'(MIN_VERTS + 1)) ? S_FINAL : S_RD0;
          end
        end else if ((i_r + CW'(1)) == n_r) begin
          state_nxt = S_FAULT;
        end else begin
          a_nxt     = b_r;
          b_nxt     = c_r;
          c_nxt     = cn_r;
          tri_nxt.a = tri_r.b;
          tri_nxt.b = tri_r.c;
          rd_addr   = cn_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_RD3;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          push     = 1'b1;
          push_end = 1'b1;
          if (head_r == a_r) begin
            push_first  = CORNER_W'(a_r);
            push_middle = CORNER_W'(c_r);
            push_third  = CORNER_W'(cn_r);
          end else if (head_r == c_r) begin
            push_first  = CORNER_W'(c_r);
            push_middle = CORNER_W'(cn_r);
            push_third  = CORNER_W'(a_r);
          end else begin
            push_first  = CORNER_W'(cn_r);
            push_middle = CORNER_W'(a_r);
            push_third  = CORNER_W'(c_r);
          end
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_FAULT: begin
        if (slot_free) begin
          push       = 1'b1;
          push_fault = 1'b1;
          push_end   = 1'b1;
          cnt_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      i_r         <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      head_r  <= head_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    cn_r  <= cn_nxt;
    tri_r <= tri_nxt;
    if (push) begin
      first_r  <= push_first;
      middle_r <= push_middle;
      third_r  <= push_third;
      fault_r  <= push_fault;
      end_r    <= push_end;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_first  = first_r;
  assign out_corner_middle = middle_r;
  assign out_corner_third  = third_r;
  assign out_fault         = fault_r;
  assign out_run_end       = end_r;

  a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!out_valid_r || out_ready))
    else $error("result pushed over an untaken result");

  a_fault_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fault) |-> (out_run_end && out_corner_first == '0 &&
      out_corner_middle == '0 && out_corner_third == '0))
    else $error("malformed fault result");

  a_ring_size: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST) |-> (n_r > CW'(MIN_VERTS) && i_r < n_r))
    else $error("ring size or scan position out of range");

  a_load_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_end) |=> (state_r == S_LOAD && cnt_r == '0 && !ovf_r))
    else $error("no restart after last result");

endmodule
